// File: sv/gyro_bias_deadband_calibrator_core_defines.svh
// Assertion helpers for the gyro bias calibrator.
`ifndef GYRO_BIAS_DEADBAND_CALIBRATOR_CORE_DEFINES_SVH
`define GYRO_BIAS_DEADBAND_CALIBRATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define GBDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GBDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/gbdc_pkg.sv
// ----------------------------------------------------------------------------
// gbdc_pkg
// Shared types and constants for the gyro bias / deadband calibrator.
// ----------------------------------------------------------------------------
package gbdc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned NoiseW  = 15;
  localparam int unsigned NumAxes = 3;

  typedef logic signed [SampleW-1:0] sample_t;

  // Per-lane control from the top level for one accepted transfer.
  typedef struct packed {
    logic acc;   // calibration sample accepted
    logic last;  // final calibration sample: latch bias
  } lane_ctrl_t;

endpackage

// File: sv/gbdc_if.sv
// ----------------------------------------------------------------------------
// gbdc_in_if / gbdc_out_if
// Valid/ready channels for raw rate samples and calibrated results.
// ----------------------------------------------------------------------------
interface gbdc_in_if import gbdc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t rate_x;
  sample_t rate_y;
  sample_t rate_z;

  modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
  modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

interface gbdc_out_if import gbdc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t cal_x;
  sample_t cal_y;
  sample_t cal_z;

  modport source (output valid, output cal_x, output cal_y, output cal_z, input ready);
  modport sink   (input valid, input cal_x, input cal_y, input cal_z, output ready);
endinterface

// File: sv/gbdc_lane.sv
// ----------------------------------------------------------------------------
// gbdc_lane
// One axis: calibration sum, peak threshold, bias, and deadband correction.
// ----------------------------------------------------------------------------
module gbdc_lane import gbdc_pkg::*; #(
  parameter int unsigned CAL_SHIFT = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  lane_ctrl_t ctrl,
  input  sample_t    sample,
  output sample_t    cal
);

  localparam int unsigned SumW = SampleW + CAL_SHIFT;

  logic signed [SumW-1:0]  sum_r, sum_nxt, sum_shr;
  logic        [NoiseW-1:0] noise_r;
  sample_t                 bias_r;
  sample_t                 diff;
  logic        [SampleW-1:0] mag;

  assign sum_nxt = sum_r + SumW'(sample);
  assign sum_shr = sum_nxt >>> CAL_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      noise_r <= '0;
      bias_r  <= '0;
    end else if (ctrl.acc) begin
      sum_r <= sum_nxt;
      if (sample > $signed({1'b0, noise_r})) begin
        noise_r <= sample[NoiseW-1:0];
      end
      if (ctrl.last) begin
        bias_r <= sum_shr[SampleW-1:0];
      end
    end
  end

  // -32768 maps to magnitude 32768, never below a 15-bit threshold
  always_comb begin
    diff = sample - bias_r;
    mag  = diff[SampleW-1] ? SampleW'(-diff) : SampleW'(diff);
    cal  = (mag < {1'b0, noise_r}) ? '0 : diff;
  end

endmodule

// File: sv/gbdc_merge.sv
// ----------------------------------------------------------------------------
// gbdc_merge
// Gathers the three lane results into the output register.
// ----------------------------------------------------------------------------
module gbdc_merge import gbdc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  sample_t lane_cal [NumAxes],
  output logic  space,
  gbdc_out_if.source out_ch
);

  logic    valid_r;
  sample_t cal_x_r, cal_y_r, cal_z_r;

  assign space = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      cal_x_r <= lane_cal[0];
      cal_y_r <= lane_cal[1];
      cal_z_r <= lane_cal[2];
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.cal_x = cal_x_r;
  assign out_ch.cal_y = cal_y_r;
  assign out_ch.cal_z = cal_z_r;

endmodule

// File: sv/gyro_bias_deadband_calibrator_core.sv
// ----------------------------------------------------------------------------
// gyro_bias_deadband_calibrator_core
// Three-axis gyro zero-offset removal with a per-axis noise deadband.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one three-axis rate sample per transfer; out_ch carries one
//   calibrated sample per transfer. Both are valid/ready channels.
//   After reset the first 2^CAL_SHIFT input transfers are calibration samples
//   and produce no output. Their per-axis sums give the bias (sum >>> shift)
//   and their per-axis positive peaks give the deadband thresholds.
//   Each later input produces one output in the cycle after acceptance, taken
//   from the output register. Three axis lanes run in parallel; the merge
//   stage's output register sets the rate at one sample per cycle while the receiver does not stall.
//   in_ch.ready stays high while the output register is empty or being
//   drained, so a new sample is taken in the same cycle a result leaves.
//   When the receiver stalls, the result holds and input is stalled.
//   Reset clears the sums, thresholds, biases and calibration count, so a
//   new calibration pass starts after every reset.
// ----------------------------------------------------------------------------
`include "gyro_bias_deadband_calibrator_core_defines.svh"

module gyro_bias_deadband_calibrator_core import gbdc_pkg::*; #(
  parameter int unsigned CAL_SHIFT = 7
) (
  input  logic clk,
  input  logic rst_n,
  gbdc_in_if.sink    in_ch,
  gbdc_out_if.source out_ch
);

  localparam int unsigned CntW = CAL_SHIFT + 1;
  localparam logic [CntW-1:0] LastCnt = CntW'((1 << CAL_SHIFT) - 1);

  logic [CntW-1:0] cal_cnt_r, cal_cnt_nxt;
  logic            cal_done;
  logic            space;
  logic            in_xfer;
  lane_ctrl_t      lane_ctrl;
  sample_t         lane_in  [NumAxes];
  sample_t         lane_cal [NumAxes];

  assign cal_done    = cal_cnt_r[CAL_SHIFT];
  assign in_ch.ready = space;
  assign in_xfer     = in_ch.valid && space;

  assign lane_ctrl.acc  = in_xfer && !cal_done;
  assign lane_ctrl.last = cal_cnt_r == LastCnt;

  assign cal_cnt_nxt = cal_cnt_r + CntW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_cnt_r <= '0;
    end else if (lane_ctrl.acc) begin
      cal_cnt_r <= cal_cnt_nxt;
    end
  end

  assign lane_in[0] = in_ch.rate_x;
  assign lane_in[1] = in_ch.rate_y;
  assign lane_in[2] = in_ch.rate_z;

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    gbdc_lane #(
      .CAL_SHIFT (CAL_SHIFT)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (lane_ctrl),
      .sample (lane_in[g]),
      .cal    (lane_cal[g])
    );
  end

  gbdc_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_xfer && cal_done),
    .lane_cal (lane_cal),
    .space    (space),
    .out_ch   (out_ch)
  );

  `GBDC_ASSERT_NOW(a_no_out_while_cal, clk, rst_n, !cal_done, !out_ch.valid, "result during calibration")
  `GBDC_ASSERT_NEXT(a_last_sets_done, clk, rst_n, lane_ctrl.acc && lane_ctrl.last, cal_done, "calibration did not end")
  `GBDC_ASSERT_NEXT(a_cnt_frozen, clk, rst_n, cal_done, $stable(cal_cnt_r), "count moved after calibration")
  `GBDC_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_ch.valid, in_ch.ready, "stalled with empty output")

endmodule
